// ===== sv/b64d_pkg.sv =====
// Shared types, constants and helper functions for the base64 stream decoder.
// No dependencies; imported by every module of the block.
package b64d_pkg;

	localparam int unsigned MAX_RES    = 4;
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned LVL_W      = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned NRES_W     = $clog2(MAX_RES + 1);
	localparam int unsigned SLOT_W     = $clog2(MAX_RES);

	localparam logic [7:0] CH_PAD    = 8'h3D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	localparam logic [7:0] LO_OFFSET  = 8'd26;
	localparam logic [7:0] DIG_OFFSET = 8'd52;
	localparam logic [5:0] SX_62      = 6'd62;
	localparam logic [5:0] SX_63      = 6'd63;

	typedef enum logic [3:0] {
		PH_COLLECT = 4'b0001,
		PH_WAITPAD = 4'b0010,
		PH_DONE    = 4'b0100,
		PH_ERROR   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eos;
		logic       malformed;
		logic       last;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0]  res;
		logic [NRES_W-1:0]   num;
	} bundle_t;

	typedef struct packed {
		logic             room;
		logic [LVL_W-1:0] level;
	} fifo_stat_t;

	// {valid, sextet}
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c >= CH_UP_A && c <= CH_UP_Z) begin
				t = c - CH_UP_A;
				return {1'b1, t[5:0]};
			end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
				t = c - CH_LO_A + LO_OFFSET;
				return {1'b1, t[5:0]};
			end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
				t = c - CH_DIG_0 + DIG_OFFSET;
				return {1'b1, t[5:0]};
			end else if (c == CH_PLUS || c == CH_MINUS) begin
				return {1'b1, SX_62};
			end else if (c == CH_SLASH || c == CH_UNDER) begin
				return {1'b1, SX_63};
			end
			return {1'b0, t[5:0]};
		end
	endfunction

	function automatic logic is_white(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_HT && c <= CH_CR);
	endfunction

	function automatic res_t data_res(input logic [7:0] b);
		res_t r;
		begin
			r = '0;
			r.data = b;
			r.has_byte = 1'b1;
			return r;
		end
	endfunction

endpackage

// ===== sv/base64_stream_decoder_unit.sv =====
// Top level of the base64 stream decoder: input register, decoder, result queue.
// Depends on b64d_pkg, b64d_decode and b64d_res_fifo.
//
// Takes one character per cycle while in_stall is low and gives one result word per cycle
// while results are queued and out_stall is low. A character is registered, decoded from
// that register, and its zero to four results are written into an eight-entry result queue
// whose head drives the output. The input stalls only while the queue holds more than four
// results, so with the output never stalled a steady text runs at one character per cycle
// (a group of four characters yields three bytes). The closing word (end_of_stream set) follows
// the tail bytes of the character marked last_char and carries malformed for the whole stream.
module base64_stream_decoder_unit
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       end_of_stream,
	output logic       malformed,
	output logic       last_of_run
);

	logic       ign_q;
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       adv;
	logic       in_take;
	logic       out_take;
	bundle_t    bundle;
	res_t       head;
	fifo_stat_t stat;

	assign adv      = valid_s1 && stat.room;
	assign in_stall = valid_s1 && !stat.room;
	assign in_take  = in_valid && !in_stall;
	assign out_valid = stat.level != '0;
	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ign_q <= 1'b0;
		else if (cfg_wr_en)
			ign_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= char_in;
			last_s1 <= last_char;
		end
	end

	b64d_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.char_s1 (char_s1),
		.last_s1 (last_s1),
		.ign     (ign_q),
		.bundle  (bundle)
	);

	b64d_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv),
		.bundle (bundle),
		.pop    (out_take),
		.head   (head),
		.stat   (stat)
	);

	assign out_byte      = head.data;
	assign has_byte      = head.has_byte;
	assign end_of_stream = head.eos;
	assign malformed     = head.malformed;
	assign last_of_run   = head.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level <= LVL_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_close_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_stream |-> last_of_run && !has_byte)
		else $error("closing word not last of its run");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_byte |-> !malformed && !end_of_stream)
		else $error("data word flagged as closing");

	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && out_take |=> stat.level == $past(stat.level) - LVL_W'(1))
		else $error("queue level off after pop");

endmodule

// ===== sv/b64d_decode.sv =====
// Decode state (phase, symbol count, sextet store) and per-character result bundle.
// Depends on b64d_pkg.
module b64d_decode
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] char_s1,
	input  logic       last_s1,
	input  logic       ign,
	output bundle_t    bundle
);

	phase_t      phase_q, ph_n, ph_f;
	logic [1:0]  cnt_q, cnt_n, cnt_f;
	logic [17:0] store_q, st_n, st_f;

	always_comb begin
		logic [6:0]        sx;
		logic              sv;
		logic              pad;
		logic              white;
		logic              grp;
		logic              bad;
		logic [23:0]       w;
		logic [NRES_W-1:0] n;
		logic [NRES_W-1:0] nl;
		sx    = sextet_of(char_s1);
		sv    = sx[6];
		pad   = char_s1 == CH_PAD;
		white = is_white(char_s1);
		grp   = 1'b0;
		w     = {store_q, sx[5:0]};
		ph_n  = phase_q;
		cnt_n = cnt_q;
		st_n  = store_q;
		case (phase_q)
			PH_COLLECT: begin
				if (sv) begin
					if (cnt_q == 2'd3) begin
						grp   = 1'b1;
						cnt_n = 2'd0;
						st_n  = '0;
					end else begin
						st_n  = {store_q[11:0], sx[5:0]};
						cnt_n = cnt_q + 2'd1;
					end
				end else if (pad) begin
					if (cnt_q == 2'd3)
						ph_n = PH_DONE;
					else if (cnt_q == 2'd2)
						ph_n = PH_WAITPAD;
					else
						ph_n = PH_ERROR;
				end else if (!white && !ign) begin
					ph_n = PH_ERROR;
				end
			end
			PH_WAITPAD: begin
				if (pad)
					ph_n = PH_DONE;
				else if (!white && !ign)
					ph_n = PH_ERROR;
			end
			default: ;
		endcase

		bad = ph_n == PH_ERROR || ph_n == PH_WAITPAD || cnt_n == 2'd1;
		bundle = '0;
		n = '0;
		if (grp) begin
			bundle.res[0] = data_res(w[23:16]);
			bundle.res[1] = data_res(w[15:8]);
			bundle.res[2] = data_res(w[7:0]);
			n = NRES_W'(3);
		end
		ph_f  = ph_n;
		cnt_f = cnt_n;
		st_f  = st_n;
		if (last_s1) begin
			if (!bad && cnt_n == 2'd2) begin
				bundle.res[n[SLOT_W-1:0]] = data_res(st_n[11:4]);
				n = n + NRES_W'(1);
			end else if (!bad && cnt_n == 2'd3) begin
				bundle.res[n[SLOT_W-1:0]] = data_res(st_n[17:10]);
				n = n + NRES_W'(1);
				bundle.res[n[SLOT_W-1:0]] = data_res(st_n[9:2]);
				n = n + NRES_W'(1);
			end
			bundle.res[n[SLOT_W-1:0]].eos       = 1'b1;
			bundle.res[n[SLOT_W-1:0]].malformed = bad;
			n = n + NRES_W'(1);
			ph_f  = PH_COLLECT;
			cnt_f = 2'd0;
			st_f  = '0;
		end
		nl = n - NRES_W'(1);
		if (n != '0)
			bundle.res[nl[SLOT_W-1:0]].last = 1'b1;
		bundle.num = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COLLECT;
			cnt_q   <= 2'd0;
			store_q <= '0;
		end else if (adv) begin
			phase_q <= ph_f;
			cnt_q   <= cnt_f;
			store_q <= st_f;
		end
	end

endmodule

// ===== sv/b64d_res_fifo.sv =====
// Result queue: takes up to MAX_RES results per cycle on push, hands out one per cycle on pop.
// Depends on b64d_pkg.
module b64d_res_fifo
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  bundle_t    bundle,
	input  logic       pop,
	output res_t       head,
	output fifo_stat_t stat
);

	res_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic [NRES_W-1:0] push_n;

	assign push_n    = push ? bundle.num : '0;
	assign head      = mem_q[rd_ptr_q];
	assign stat.level = level_q;
	assign stat.room  = level_q <= LVL_W'(FIFO_DEPTH - MAX_RES);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (NRES_W'(i) < push_n)
				mem_q[wr_ptr_q + PTR_W'(i)] <= bundle.res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			level_q  <= level_q + LVL_W'(push_n) - LVL_W'(pop);
		end
	end

endmodule
